// File: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error(msg);

`endif

// File: rtl/brd_pkg.sv
package brd_pkg;

    localparam int GRID_COLS_DEF = 32;
    localparam int QW            = 32;
    localparam int FRAC          = 24;

    typedef logic signed [QW-1:0] t_q;

    localparam logic [2:0] REG_DU   = 3'd0;
    localparam logic [2:0] REG_DV   = 3'd1;
    localparam logic [2:0] REG_KU   = 3'd2;
    localparam logic [2:0] REG_KV   = 3'd3;
    localparam logic [2:0] REG_IA   = 3'd4;
    localparam logic [2:0] REG_B    = 3'd5;
    localparam logic [2:0] REG_COLS = 3'd6;
    localparam logic [2:0] REG_ROWS = 3'd7;

    localparam logic signed [QW-1:0] Q_ONE = 32'sd16777216;

    // Saturate a 66-bit signed value to 32 bits.
    function automatic t_q sat(input logic signed [65:0] x);
        if (x > 66'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (x < -66'sh80000000) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // Product a*b shifted right by 24 with floor, saturated.
    function automatic t_q qshift(input logic signed [63:0] p);
        logic signed [65:0] s;
        s = 66'(p >>> FRAC);
        return sat(s);
    endfunction

    // One stencil operand set handed through the cell row.
    typedef struct packed {
        logic   vld;
        logic   last;
        logic   flast;
        t_q     cu;
        t_q     cv;
        t_q     nu0;
        t_q     nu1;
        t_q     nu2;
        t_q     nu3;
        t_q     nv0;
        t_q     nv1;
        t_q     nv2;
        t_q     nv3;
    } t_job;

    typedef struct packed {
        logic [30:0] du;
        logic [30:0] dv;
        logic [30:0] ku;
        logic [30:0] kv;
        logic [30:0] ia;
        t_q          b;
    } t_cfg;

endpackage

// File: rtl/brd_ram.sv
module brd_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;
endmodule

// File: rtl/brd_cell.sv
// One stage of the update chain: each cell does one saturating arithmetic
// step of the cell update and hands the partial results to its neighbor.
module brd_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  brd_pkg::t_cfg  i_cfg,
    input  brd_pkg::t_job  i_job,
    input  brd_pkg::t_q    i_a [6],
    output brd_pkg::t_job  o_job,
    output brd_pkg::t_q    o_a [6]
);
    import brd_pkg::*;

    t_job r_job;
    t_q   r_a [6];
    t_q   n_a [6];
    logic signed [35:0] lu, lv;
    logic signed [63:0] pu_hi, pu_lo, pv_hi, pv_lo;
    logic signed [65:0] wu, wv;

    // Slots: 0 du, 1 dv, 2 vb/q/w/p/ru, 3 om/u*om, 4 u2/u3/d/rv, 5 spare
    always_comb begin
        lu = 36'(i_job.nu0) + 36'(i_job.nu1) + 36'(i_job.nu2) + 36'(i_job.nu3)
             - (36'(i_job.cu) <<< 2);
        lv = 36'(i_job.nv0) + 36'(i_job.nv1) + 36'(i_job.nv2) + 36'(i_job.nv3)
             - (36'(i_job.cv) <<< 2);
        pu_hi = 64'(lu) * $signed({49'd0, i_cfg.du[30:16]});
        pu_lo = 64'(lu) * $signed({48'd0, i_cfg.du[15:0]});
        pv_hi = 64'(lv) * $signed({49'd0, i_cfg.dv[30:16]});
        pv_lo = 64'(lv) * $signed({48'd0, i_cfg.dv[15:0]});
        wu = 66'(pu_hi) + 66'(pu_lo >>> 16);
        wv = 66'(pv_hi) + 66'(pv_lo >>> 16);
        for (int k = 0; k < 6; k++) begin
            n_a[k] = i_a[k];
        end
        case (STAGE)
            0: begin
                n_a[0] = sat(wu >>> 8);
                n_a[1] = sat(wv >>> 8);
                n_a[2] = sat(66'(i_job.cv) + 66'(i_cfg.b));
                n_a[3] = sat(66'(Q_ONE) - 66'(i_job.cu));
                n_a[4] = qshift(64'(i_job.cu) * 64'(i_job.cu));
            end
            1: begin
                n_a[2] = qshift(64'(i_a[2]) * $signed({33'd0, i_cfg.ia}));
                n_a[3] = qshift(64'(i_job.cu) * 64'(i_a[3]));
                n_a[4] = qshift(64'(i_a[4]) * 64'(i_job.cu));
            end
            2: begin
                n_a[2] = sat(66'(i_job.cu) - 66'(i_a[2]));
                n_a[4] = sat(66'(i_a[4]) - 66'(i_job.cv));
            end
            3: begin
                n_a[2] = qshift(64'(i_a[3]) * 64'(i_a[2]));
                n_a[4] = qshift(64'(i_a[4]) * $signed({33'd0, i_cfg.kv}));
            end
            4: begin
                n_a[2] = qshift(64'(i_a[2]) * $signed({33'd0, i_cfg.ku}));
            end
            default: begin
                n_a[0] = sat(66'(i_job.cu) + 66'(i_a[0]) + 66'(i_a[2]));
                n_a[1] = sat(66'(i_job.cv) + 66'(i_a[1]) + 66'(i_a[4]));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job.vld <= 1'b0;
        end else if (i_adv) begin
            r_job.vld <= i_job.vld;
        end
        if (i_adv) begin
            r_job.last  <= i_job.last;
            r_job.flast <= i_job.flast;
            r_job.cu    <= i_job.cu;
            r_job.cv    <= i_job.cv;
            r_job.nu0   <= i_job.nu0;
            r_job.nu1   <= i_job.nu1;
            r_job.nu2   <= i_job.nu2;
            r_job.nu3   <= i_job.nu3;
            r_job.nv0   <= i_job.nv0;
            r_job.nv1   <= i_job.nv1;
            r_job.nv2   <= i_job.nv2;
            r_job.nv3   <= i_job.nv3;
            r_a         <= n_a;
        end
    end

    assign o_job = r_job;
    assign o_a   = r_a;
endmodule

// File: rtl/brd_ctrl.sv
// Sequencer: reads the two line stores for each stencil, issues one job per
// transfer after the first row and at frame end sweeps the last row.
module brd_ctrl #(
    parameter int GRID_COLS = brd_pkg::GRID_COLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  brd_pkg::t_q   i_u,
    input  brd_pkg::t_q   i_v,
    input  logic [5:0]    i_cols,
    input  logic [11:0]   i_rows,
    input  logic          i_room,
    output brd_pkg::t_job o_job,
    output logic          o_busy
);
    import brd_pkg::*;

    localparam int CW = $clog2(GRID_COLS + 1);
    localparam int AW = $clog2(2 * GRID_COLS);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]    r_st;
    logic [CW-1:0] r_col, r_fc;
    logic [11:0]   r_row;
    t_q            r_cu, r_cv;
    logic [CW-1:0] cols_e, col_e, c_sel, rc;
    logic [11:0]   rows_e, row_e;
    logic          par, in_acc, lastcell, half;
    logic [1:0]    r_ph, r_ph_d;
    logic          r_rdv, r_infl;
    t_q            r_mu, r_mv, r_upu, r_upv, r_lu, r_lv, r_ru, r_rv;
    logic [AW-1:0] ra, wa;
    logic          we;
    logic [63:0]   rd;

    always_comb begin
        cols_e = (i_cols < 6'd3) ? CW'(3) :
                 (32'(i_cols) > GRID_COLS) ? CW'(GRID_COLS) : CW'(i_cols);
        rows_e = (i_rows < 12'd3) ? 12'd3 : i_rows;
        col_e  = (r_col >= cols_e) ? cols_e - CW'(1) : r_col;
        row_e  = (r_row >= rows_e) ? rows_e - 12'd1 : r_row;
        par    = row_e[0];
        lastcell = (row_e == rows_e - 12'd1) && (col_e == cols_e - CW'(1));
    end

    assign in_acc     = i_in_valid && (r_st == S_IDLE);
    assign o_in_stall = (r_st != S_IDLE);
    assign o_busy     = (r_st != S_IDLE);

    // Read sequence: centre, left, right, then the entry of the other half
    always_comb begin
        c_sel = r_infl ? r_fc : col_e;
        case (r_ph)
            2'd1: rc = (c_sel != '0) ? c_sel - CW'(1) : c_sel;
            2'd2: rc = (c_sel + CW'(1) < cols_e) ? c_sel + CW'(1) : c_sel;
            default: rc = c_sel;
        endcase
        // Normal: first three from the row above, last from two rows up.
        // Flush: first three from the last row, last from the row above.
        half = par ^ r_infl ^ (r_ph != 2'd3);
        ra = AW'(32'(half) * GRID_COLS + 32'(rc));
        we = (r_st == S_EMIT) && !r_infl && i_room;
        wa = AW'(32'(par) * GRID_COLS + 32'(col_e));
    end

    brd_ram #(.W(64), .D(2 * GRID_COLS)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(wa), .i_wdata({r_cu, r_cv}),
        .i_raddr(ra), .o_rdata(rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_col  <= '0;
            r_row  <= '0;
            r_ph   <= '0;
            r_rdv  <= 1'b0;
            r_infl <= 1'b0;
        end else begin
            r_rdv <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cu <= i_u;
                        r_cv <= i_v;
                        r_ph <= 2'd0;
                        r_st <= S_RD;
                    end
                end
                S_RD: begin
                    r_ph_d <= r_ph;
                    r_rdv  <= 1'b1;
                    r_ph   <= r_ph + 2'd1;
                    if (r_ph == 2'd3) begin
                        r_st <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_room) begin
                        if (r_infl) begin
                            if (r_fc == cols_e - CW'(1)) begin
                                r_infl <= 1'b0;
                                r_col  <= '0;
                                r_row  <= '0;
                                r_st   <= S_IDLE;
                            end else begin
                                r_fc <= r_fc + CW'(1);
                                r_ph <= 2'd0;
                                r_st <= S_RD;
                            end
                        end else if (lastcell) begin
                            r_infl <= 1'b1;
                            r_fc   <= '0;
                            r_ph   <= 2'd0;
                            r_st   <= S_RD;
                        end else begin
                            r_st <= S_IDLE;
                            if (col_e + CW'(1) >= cols_e) begin
                                r_col <= '0;
                                r_row <= row_e + 12'd1;
                            end else begin
                                r_col <= col_e + CW'(1);
                                r_row <= row_e;
                            end
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_rdv) begin
                case (r_ph_d)
                    2'd0: begin r_mu <= rd[63:32]; r_mv <= rd[31:0]; end
                    2'd1: begin r_lu <= rd[63:32]; r_lv <= rd[31:0]; end
                    2'd2: begin r_ru <= rd[63:32]; r_rv <= rd[31:0]; end
                    default: begin r_upu <= rd[63:32]; r_upv <= rd[31:0]; end
                endcase
            end
        end
    end

    always_comb begin
        o_job       = '0;
        o_job.cu    = r_mu;
        o_job.cv    = r_mv;
        o_job.nu1   = r_infl ? r_mu : r_cu;
        o_job.nv1   = r_infl ? r_mv : r_cv;
        o_job.nu0   = (r_infl || row_e >= 12'd2) ? r_upu : r_mu;
        o_job.nv0   = (r_infl || row_e >= 12'd2) ? r_upv : r_mv;
        o_job.nu2   = r_lu;
        o_job.nv2   = r_lv;
        o_job.nu3   = r_ru;
        o_job.nv3   = r_rv;
        o_job.vld   = (r_st == S_EMIT) && i_room && (r_infl || row_e >= 12'd1);
        o_job.last  = r_infl ? (r_fc == cols_e - CW'(1)) : !lastcell;
        o_job.flast = r_infl && (r_fc == cols_e - CW'(1));
    end
endmodule

// File: rtl/barkley_reaction_diffusion_step_unit.sv
// Barkley model, one explicit Euler step per grid cell, cells fed in raster
// order, results one row behind. From its transfer to the next possible
// transfer each input goes through a capture step, four reads of the combined
// line store port (centre above, left, right, two rows up), a wait for the
// last read to land and an issue step, which holds while the queue lacks room.
// The last cell of a frame then sweeps the last row with the same read, wait
// and issue steps per column. A result passes the six-cell multiply chain and
// is then written to the queue before it is offered. Results leave through an
// eight-entry output queue; the sequencer holds its issue, and so the input,
// while queue and chain together hold eight results. Line stores start
// undefined; no clearing pass.
`include "assert_macros.svh"
module barkley_reaction_diffusion_step_unit #(
    parameter int GRID_COLS = brd_pkg::GRID_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  brd_pkg::t_q i_u_cell,
    input  brd_pkg::t_q i_v_cell,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output brd_pkg::t_q o_u_next,
    output brd_pkg::t_q o_v_next,
    output logic        o_run_last,
    output logic        o_frame_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import brd_pkg::*;

    localparam int NC = 6;
    localparam int QD = 8;

    t_cfg r_cfg;
    logic [5:0]  r_cols;
    logic [11:0] r_rows;
    t_job jobs [NC+1];
    t_q   acc  [NC+1][6];
    logic busy, room;
    logic [3:0] r_cnt;
    logic [3:0] inflight;
    t_job j0;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.du <= 31'd83886;
            r_cfg.dv <= 31'd0;
            r_cfg.ku <= 31'd838861;
            r_cfg.kv <= 31'd16777;
            r_cfg.ia <= 31'd22369621;
            r_cfg.b  <= 32'sd1006633;
            r_cols   <= 6'd32;
            r_rows   <= 12'd50;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DU:   r_cfg.du <= i_cfg_data[30:0];
                REG_DV:   r_cfg.dv <= i_cfg_data[30:0];
                REG_KU:   r_cfg.ku <= i_cfg_data[30:0];
                REG_KV:   r_cfg.kv <= i_cfg_data[30:0];
                REG_IA:   r_cfg.ia <= i_cfg_data[30:0];
                REG_B:    r_cfg.b  <= i_cfg_data;
                REG_COLS: r_cols   <= i_cfg_data[5:0];
                REG_ROWS: r_rows   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Chain always advances; the queue leaves room for everything in flight.
    assign room = (32'(r_cnt) + 32'(inflight)) < QD;

    brd_ctrl #(.GRID_COLS(GRID_COLS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_u(i_u_cell), .i_v(i_v_cell), .i_cols(r_cols), .i_rows(r_rows),
        .i_room(room), .o_job(j0), .o_busy(busy)
    );

    assign jobs[0] = j0;
    assign acc[0]  = '{default: '0};

    always_comb begin
        inflight = '0;
        for (int s = 1; s <= NC; s++) inflight = inflight + 4'(jobs[s].vld);
    end

    for (genvar g = 0; g < NC; g++) begin : g_cell
        brd_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(1'b1), .i_cfg(r_cfg),
            .i_job(jobs[g]), .i_a(acc[g]), .o_job(jobs[g+1]), .o_a(acc[g+1])
        );
    end

    // Output queue.
    logic [65:0] r_q [QD];
    logic [2:0]  r_wp, r_rp;
    logic        pop;
    assign pop = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (jobs[NC].vld) begin
                r_wp <= r_wp + 3'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 3'd1;
            end
            r_cnt <= r_cnt + 4'(jobs[NC].vld) - 4'(pop);
        end
        if (jobs[NC].vld) begin
            r_q[r_wp] <= {acc[NC][0], acc[NC][1], jobs[NC].last, jobs[NC].flast};
        end
    end

    assign o_out_valid  = (r_cnt != 4'd0);
    assign o_u_next     = r_q[r_rp][65:34];
    assign o_v_next     = r_q[r_rp][33:2];
    assign o_run_last   = r_q[r_rp][1];
    assign o_frame_last = r_q[r_rp][0];

    `ASSERT_IMPL(a_qbound, i_clk, i_rst_n, 1'b1, r_cnt <= 4'(QD), "queue overflow")
    `ASSERT_IMPL(a_fl_rl, i_clk, i_rst_n, o_out_valid && o_frame_last, o_run_last,
                 "frame end without run end")
    `ASSERT_NEXT(a_busy, i_clk, i_rst_n, !o_in_stall && i_in_valid, busy,
                 "sequencer did not start")
endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import brd_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        t_q u;
        t_q v;
    } cell_t;

    typedef struct {
        t_q   u;
        t_q   v;
        logic run_last;
        logic frame_last;
    } cell_res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_q          i_u_cell = '0;
    t_q          i_v_cell = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_q          o_u_next;
    t_q          o_v_next;
    logic        o_run_last;
    logic        o_frame_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    barkley_reaction_diffusion_step_unit u_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // model copy of the registers and the grid state
    logic [30:0] m_du, m_dv, m_ku, m_kv, m_ia;
    t_q          m_b;
    logic [5:0]  m_cols;
    logic [11:0] m_rows;
    t_q          u_line[64];
    t_q          v_line[64];
    int unsigned col_cnt, row_cnt;

    cell_t       cell_q[$];
    cell_res_t   cell_res_q[$];
    int          mismatches = 0;
    int          items_sent = 0;

    function automatic t_q sat32(input wide_t x);
        if (x > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (x < -128'sh80000000) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic t_q mul24(input wide_t a, input wide_t b);
        return sat32((a * b) >>> 24);
    endfunction

    function automatic cell_res_t update_cell(input t_q cu, input t_q cv,
                                              input t_q nu[4], input t_q nv[4]);
        wide_t     lu, lv;
        t_q        du, dv, vb, q, w, om, p, ru, u3, d, rv;
        cell_res_t r;
        lu = 0;
        lv = 0;
        for (int k = 0; k < 4; k++) begin
            lu += wide_t'(nu[k]) - wide_t'(cu);
            lv += wide_t'(nv[k]) - wide_t'(cv);
        end
        du = sat32((lu * wide_t'({1'b0, m_du})) >>> 24);
        dv = sat32((lv * wide_t'({1'b0, m_dv})) >>> 24);
        vb = sat32(wide_t'(cv) + wide_t'(m_b));
        q  = mul24(wide_t'(vb), wide_t'({1'b0, m_ia}));
        w  = sat32(wide_t'(cu) - wide_t'(q));
        om = sat32(wide_t'(Q_ONE) - wide_t'(cu));
        p  = mul24(wide_t'(mul24(wide_t'(cu), wide_t'(om))), wide_t'(w));
        ru = mul24(wide_t'(p), wide_t'({1'b0, m_ku}));
        u3 = mul24(wide_t'(mul24(wide_t'(cu), wide_t'(cu))), wide_t'(cu));
        d  = sat32(wide_t'(u3) - wide_t'(cv));
        rv = sat32((wide_t'(d) * wide_t'({1'b0, m_kv})) >>> 24);
        r.u = sat32(wide_t'(cu) + wide_t'(du) + wide_t'(ru));
        r.v = sat32(wide_t'(cv) + wide_t'(dv) + wide_t'(rv));
        r.run_last = 1'b0;
        r.frame_last = 1'b0;
        return r;
    endfunction

    function automatic void step_grid(input cell_t c_in);
        int unsigned cols, rows, col, row, cur, oth;
        t_q          mu, mv;
        t_q          nu[4], nv[4];
        cell_res_t   r;
        int          n;
        n = 0;
        cols = (m_cols < 3) ? 3 : (m_cols > 32) ? 32 : m_cols;
        rows = (m_rows < 3) ? 3 : m_rows;
        col = (col_cnt >= cols) ? cols - 1 : col_cnt;
        row = (row_cnt >= rows) ? rows - 1 : row_cnt;
        cur = (row & 1) * 32;
        oth = (1 - (row & 1)) * 32;
        if (row >= 1) begin
            mu = u_line[oth + col];
            mv = v_line[oth + col];
            nu[0] = (row >= 2) ? u_line[cur + col] : mu;
            nv[0] = (row >= 2) ? v_line[cur + col] : mv;
            nu[1] = c_in.u;
            nv[1] = c_in.v;
            nu[2] = (col > 0) ? u_line[oth + col - 1] : mu;
            nv[2] = (col > 0) ? v_line[oth + col - 1] : mv;
            nu[3] = (col + 1 < cols) ? u_line[oth + col + 1] : mu;
            nv[3] = (col + 1 < cols) ? v_line[oth + col + 1] : mv;
            cell_res_q.push_back(update_cell(mu, mv, nu, nv));
            n++;
        end
        u_line[cur + col] = c_in.u;
        v_line[cur + col] = c_in.v;
        if (row == rows - 1 && col == cols - 1) begin
            // flush the last row
            for (int c = 0; c < cols; c++) begin
                mu = u_line[cur + c];
                mv = v_line[cur + c];
                nu[0] = u_line[oth + c];
                nv[0] = v_line[oth + c];
                nu[1] = mu;
                nv[1] = mv;
                nu[2] = (c > 0) ? u_line[cur + c - 1] : mu;
                nv[2] = (c > 0) ? v_line[cur + c - 1] : mv;
                nu[3] = (c + 1 < cols) ? u_line[cur + c + 1] : mu;
                nv[3] = (c + 1 < cols) ? v_line[cur + c + 1] : mv;
                cell_res_q.push_back(update_cell(mu, mv, nu, nv));
                n++;
            end
            cell_res_q[$].frame_last = 1'b1;
            col_cnt = 0;
            row_cnt = 0;
        end else if (col + 1 >= cols) begin
            col_cnt = 0;
            row_cnt = row + 1;
        end else begin
            col_cnt = col + 1;
            row_cnt = row;
        end
        if (n > 0) cell_res_q[$].run_last = 1'b1;
    endfunction

    // sender: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        logic moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                step_grid(cell_q.pop_front());
                moved = 1'b1;
            end
            if (!i_in_valid || moved) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (cell_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_u_cell <= cell_q[0].u;
                    i_v_cell <= cell_q[0].v;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern, quiet stretches and one long hold-off
    int  res_cnt = 0;
    int  hold_left = 0;
    bit  long_done = 0;
    int  mode = 0;
    int  mode_left = 0;
    always @(posedge i_clk) begin
        cell_res_t e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                res_cnt++;
                if (cell_res_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result u=%h v=%h",
                                                   o_u_next, o_v_next);
                end else begin
                    e = cell_res_q.pop_front();
                    if (e.u !== o_u_next || e.v !== o_v_next ||
                        e.run_last !== o_run_last || e.frame_last !== o_frame_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp u=%h v=%h rl=%b fl=%b got u=%h v=%h rl=%b fl=%b",
                                     e.u, e.v, e.run_last, e.frame_last,
                                     o_u_next, o_v_next, o_run_last, o_frame_last);
                    end
                end
            end
            if (!long_done && res_cnt >= 60) begin
                long_done = 1;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 200);
                end else begin
                    mode_left--;
                end
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    default: i_out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_DU:   m_du = data[30:0];
            REG_DV:   m_dv = data[30:0];
            REG_KU:   m_ku = data[30:0];
            REG_KV:   m_kv = data[30:0];
            REG_IA:   m_ia = data[30:0];
            REG_B:    m_b = data;
            REG_COLS: m_cols = data[5:0];
            default:  m_rows = data[11:0];
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (cell_q.size() > 0 || i_in_valid || cell_res_q.size() > 0);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_q rand_q();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0400_0000) - 32'sh0200_0000;
            2: return $urandom_range(0, 32'h0140_0000);
            3: return ($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $urandom_range(0, 32'h0020_0000) - 32'sh0010_0000 + Q_ONE;
        endcase
    endfunction

    // queue one whole frame for the present geometry
    task automatic send_frame(input bit wild);
        int   cols, rows;
        cell_t c;
        cols = (m_cols < 3) ? 3 : (m_cols > 32) ? 32 : m_cols;
        rows = (m_rows < 3) ? 3 : m_rows;
        for (int k = 0; k < cols * rows; k++) begin
            c.u = wild ? rand_q() : $urandom_range(0, 32'h0110_0000);
            c.v = wild ? rand_q() : $urandom_range(0, 32'h0080_0000);
            cell_q.push_back(c);
        end
        items_sent += cols * rows;
    endtask

    task automatic rand_gains();
        write_reg(REG_DU, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000));
        write_reg(REG_DV, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000));
        write_reg(REG_KU, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000));
        write_reg(REG_KV, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000));
        write_reg(REG_IA, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0200_0000));
        write_reg(REG_B, ($urandom_range(0, 3) == 0) ? $urandom
                                                     : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
    endtask

    initial begin
        cell_t c;
        m_du = 31'd83886;   m_dv = 31'd0;     m_ku = 31'd838861;
        m_kv = 31'd16777;   m_ia = 31'd22369621;
        m_b = 32'sd1006633; m_cols = 6'd32;   m_rows = 12'd50;
        col_cnt = 0;
        row_cnt = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 3x3 frame of extreme cells under reset gains
        write_reg(REG_COLS, 32'd3);
        write_reg(REG_ROWS, 32'd3);
        c.u = 32'sh7FFFFFFF; c.v = 32'sh80000000; cell_q.push_back(c);
        c.u = 32'sh80000000; c.v = 32'sh7FFFFFFF; cell_q.push_back(c);
        c.u = 32'sd0;        c.v = 32'sd0;        cell_q.push_back(c);
        c.u = Q_ONE;         c.v = Q_ONE;         cell_q.push_back(c);
        c.u = -32'sd1;       c.v = 32'sd1;        cell_q.push_back(c);
        c.u = 32'sh7FFFFFFF; c.v = 32'sh7FFFFFFF; cell_q.push_back(c);
        c.u = 32'sh80000000; c.v = 32'sh80000000; cell_q.push_back(c);
        c.u = 32'sh0100_0000; c.v = 32'sh0010_0000; cell_q.push_back(c);
        c.u = 32'sh0080_0000; c.v = 32'sh0001_0000; cell_q.push_back(c);
        items_sent += 9;
        wait_idle();

        // gains and offset at both ends, grid codes 0 by 0, then 63 by 4
        write_reg(REG_DU, 32'hFFFF_FFFF);
        write_reg(REG_DV, 32'h7FFF_FFFF);
        write_reg(REG_KU, 32'h7FFF_FFFF);
        write_reg(REG_KV, 32'hFFFF_FFFF);
        write_reg(REG_IA, 32'h7FFF_FFFF);
        write_reg(REG_B, 32'h7FFF_FFFF);
        write_reg(REG_COLS, 32'd0);
        write_reg(REG_ROWS, 32'd0);
        send_frame(1);
        wait_idle();
        write_reg(REG_DU, 32'd0);
        write_reg(REG_DV, 32'd0);
        write_reg(REG_KU, 32'd0);
        write_reg(REG_KV, 32'd0);
        write_reg(REG_IA, 32'd0);
        write_reg(REG_B, 32'h8000_0000);
        write_reg(REG_COLS, 32'd63);
        write_reg(REG_ROWS, 32'd4);
        send_frame(1);
        wait_idle();

        // random phases
        while (items_sent < 450) begin
            rand_gains();
            write_reg(REG_COLS, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(3, 8));
            write_reg(REG_ROWS, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6)
                                                            : $urandom_range(3, 5));
            repeat ($urandom_range(1, 2)) send_frame($urandom_range(0, 3) == 0);
            wait_idle();
        end

        if (mismatches == 0 && cell_res_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/brd_pkg.sv
rtl/brd_ram.sv
rtl/brd_cell.sv
rtl/brd_ctrl.sv
rtl/barkley_reaction_diffusion_step_unit.sv
tb/sv/tb_top.sv
